>>> sv/aluws_pkg.sv
// shared types and constants for the data-processing alu with barrel shifter
`timescale 1ns / 1ps
`default_nettype none

package aluws_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned AMT_W   = 8;
  localparam int unsigned CODE_W  = 12;
  localparam int unsigned IMM_W   = 8;
  localparam int unsigned SHAMT_W = 5;

  // operation codes in standard order
  typedef enum logic [3:0] {
    FN_AND = 4'd0,
    FN_EOR = 4'd1,
    FN_SUB = 4'd2,
    FN_RSB = 4'd3,
    FN_ADD = 4'd4,
    FN_ADC = 4'd5,
    FN_SBC = 4'd6,
    FN_RSC = 4'd7,
    FN_TST = 4'd8,
    FN_TEQ = 4'd9,
    FN_CMP = 4'd10,
    FN_CMN = 4'd11,
    FN_ORR = 4'd12,
    FN_MOV = 4'd13,
    FN_BIC = 4'd14,
    FN_MVN = 4'd15
  } func_e;

  // shift types from operand2 bits 6..5
  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_e;

  // input transaction
  typedef struct packed {
    func_e               func;
    logic [WORD_W-1:0]   rn_value;
    logic [WORD_W-1:0]   rm_value;
    logic [AMT_W-1:0]    rs_amount;
    logic [CODE_W-1:0]   operand2_code;
    logic                use_immediate;
    logic                set_flags;
    logic                carry_in;
    logic                overflow_in;
  } alu_in_t;

  // result transaction
  typedef struct packed {
    logic [WORD_W-1:0]   result_value;
    logic                write_result;
    logic                flags_valid;
    logic                flag_neg;
    logic                flag_zero;
    logic                flag_carry;
    logic                flag_over;
  } alu_out_t;

endpackage

`default_nettype wire

>>> sv/aluws_shifter.sv
// barrel shifter forming operand two and the shifter carry
`timescale 1ns / 1ps
`default_nettype none

module aluws_shifter (
  input  wire logic [aluws_pkg::WORD_W-1:0] rm_value_i,
  input  wire logic [aluws_pkg::CODE_W-1:0] operand2_code_i,
  input  wire logic [aluws_pkg::AMT_W-1:0]  rs_amount_i,
  input  wire logic                         use_immediate_i,
  input  wire logic                         carry_i,
  output logic      [aluws_pkg::WORD_W-1:0] operand_o,
  output logic                              carry_o
);

  localparam int unsigned W = aluws_pkg::WORD_W;

  aluws_pkg::shift_e          sh_type;
  logic [aluws_pkg::AMT_W-1:0] amt;
  logic                        pass;
  logic                        rrx;
  logic                        amt_big;
  logic                        amt_32;
  logic [aluws_pkg::SHAMT_W-1:0] sh5;
  logic [aluws_pkg::SHAMT_W-1:0] rot;
  logic [2*W-1:0]              imm_dbl;
  logic [W-1:0]                imm_val;
  logic [W:0]                  lsh;
  logic                        fill;
  logic [2*W:0]                rsh_in;
  logic [2*W:0]                rsh_all;
  logic [W:0]                  rsh;

  assign sh_type = aluws_pkg::shift_e'(operand2_code_i[6:5]);
  assign sh5     = amt[aluws_pkg::SHAMT_W-1:0];
  assign amt_big = (amt[aluws_pkg::AMT_W-1:aluws_pkg::SHAMT_W] != '0);
  assign amt_32  = (amt == aluws_pkg::AMT_W'(W));

  // rotated 8-bit immediate
  assign rot     = {operand2_code_i[11:8], 1'b0};
  assign imm_dbl = {{(W-aluws_pkg::IMM_W){1'b0}}, operand2_code_i[7:0],
                    {(W-aluws_pkg::IMM_W){1'b0}}, operand2_code_i[7:0]} >> rot;
  assign imm_val = imm_dbl[W-1:0];

  // amount selection: register byte or instruction field with the zero encodings
  always_comb begin
    pass = 1'b0;
    rrx  = 1'b0;
    if (operand2_code_i[4]) begin
      amt  = rs_amount_i;
      pass = (rs_amount_i == '0);
    end else begin
      amt = {{(aluws_pkg::AMT_W-aluws_pkg::SHAMT_W){1'b0}}, operand2_code_i[11:7]};
      if (operand2_code_i[11:7] == '0) begin
        case (sh_type)
          aluws_pkg::SH_LSL: pass = 1'b1;
          aluws_pkg::SH_ROR: rrx  = 1'b1;
          default:           amt  = aluws_pkg::AMT_W'(W);
        endcase
      end
    end
  end

  // one left and one right shifter, carry comes out of the extra bit
  assign lsh     = {1'b0, rm_value_i} << sh5;
  assign fill    = (sh_type == aluws_pkg::SH_ASR) & rm_value_i[W-1];
  assign rsh_in  = (sh_type == aluws_pkg::SH_ROR) ? {rm_value_i, rm_value_i, 1'b0}
                                                   : {{W{fill}}, rm_value_i, 1'b0};
  assign rsh_all = rsh_in >> sh5;
  assign rsh     = rsh_all[W:0];

  // result and carry per shift type
  always_comb begin
    operand_o = rm_value_i;
    carry_o   = carry_i;
    if (use_immediate_i) begin
      operand_o = imm_val;
      carry_o   = (rot == '0) ? carry_i : imm_val[W-1];
    end else if (pass) begin
      operand_o = rm_value_i;
      carry_o   = carry_i;
    end else if (rrx) begin
      operand_o = {carry_i, rm_value_i[W-1:1]};
      carry_o   = rm_value_i[0];
    end else begin
      case (sh_type)
        aluws_pkg::SH_LSL: begin
          if (amt_big) begin
            operand_o = '0;
            carry_o   = amt_32 & rm_value_i[0];
          end else begin
            operand_o = lsh[W-1:0];
            carry_o   = lsh[W];
          end
        end
        aluws_pkg::SH_LSR: begin
          if (amt_big) begin
            operand_o = '0;
            carry_o   = amt_32 & rm_value_i[W-1];
          end else begin
            operand_o = rsh[W:1];
            carry_o   = rsh[0];
          end
        end
        aluws_pkg::SH_ASR: begin
          if (amt_big) begin
            operand_o = {W{rm_value_i[W-1]}};
            carry_o   = rm_value_i[W-1];
          end else begin
            operand_o = rsh[W:1];
            carry_o   = rsh[0];
          end
        end
        default: begin
          if (sh5 == '0) begin
            operand_o = rm_value_i;
            carry_o   = rm_value_i[W-1];
          end else begin
            operand_o = rsh[W:1];
            carry_o   = rsh[0];
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/aluws_alu.sv
// opcode decode, adder and logic unit with nzcv flag generation
`timescale 1ns / 1ps
`default_nettype none

module aluws_alu (
  input  wire aluws_pkg::alu_in_t            in_i,
  input  wire logic [aluws_pkg::WORD_W-1:0]  operand_i,
  input  wire logic                          shift_carry_i,
  output aluws_pkg::alu_out_t                out_o
);

  localparam int unsigned W = aluws_pkg::WORD_W;

  logic [W-1:0] a;
  logic [W-1:0] x;
  logic [W-1:0] y;
  logic         cy;
  logic [W:0]   sum;
  logic         add_c;
  logic         add_v;
  logic [W-1:0] res;
  logic         logical;
  logic         c_new;
  logic         v_new;

  assign a = in_i.rn_value;

  // adder operand selection
  always_comb begin
    x  = a;
    y  = operand_i;
    cy = 1'b0;
    case (in_i.func)
      aluws_pkg::FN_SUB, aluws_pkg::FN_CMP: begin
        y  = ~operand_i;
        cy = 1'b1;
      end
      aluws_pkg::FN_RSB: begin
        x  = operand_i;
        y  = ~a;
        cy = 1'b1;
      end
      aluws_pkg::FN_ADC: cy = in_i.carry_in;
      aluws_pkg::FN_SBC: begin
        y  = ~operand_i;
        cy = in_i.carry_in;
      end
      aluws_pkg::FN_RSC: begin
        x  = operand_i;
        y  = ~a;
        cy = in_i.carry_in;
      end
      default: cy = 1'b0;
    endcase
  end

  assign sum   = {1'b0, x} + {1'b0, y} + {{W{1'b0}}, cy};
  assign add_c = sum[W];
  assign add_v = (x[W-1] ^ sum[W-1]) & (y[W-1] ^ sum[W-1]);

  // result select
  always_comb begin
    logical = 1'b1;
    case (in_i.func)
      aluws_pkg::FN_AND, aluws_pkg::FN_TST: res = a & operand_i;
      aluws_pkg::FN_EOR, aluws_pkg::FN_TEQ: res = a ^ operand_i;
      aluws_pkg::FN_ORR:                    res = a | operand_i;
      aluws_pkg::FN_MOV:                    res = operand_i;
      aluws_pkg::FN_BIC:                    res = a & ~operand_i;
      aluws_pkg::FN_MVN:                    res = ~operand_i;
      default: begin
        res     = sum[W-1:0];
        logical = 1'b0;
      end
    endcase
  end

  assign c_new = logical ? shift_carry_i : add_c;
  assign v_new = logical ? in_i.overflow_in : add_v;

  // result transaction, flags forced low when no update is requested
  always_comb begin
    out_o.result_value = res;
    out_o.write_result = !((in_i.func == aluws_pkg::FN_TST) ||
                           (in_i.func == aluws_pkg::FN_TEQ) ||
                           (in_i.func == aluws_pkg::FN_CMP) ||
                           (in_i.func == aluws_pkg::FN_CMN));
    out_o.flags_valid  = in_i.set_flags;
    out_o.flag_neg     = in_i.set_flags & res[W-1];
    out_o.flag_zero    = in_i.set_flags & (res == '0);
    out_o.flag_carry   = in_i.set_flags & c_new;
    out_o.flag_over    = in_i.set_flags & v_new;
  end

endmodule

`default_nettype wire

>>> sv/alu_with_barrel_shifter_core.sv
// top level: input register, shifter and alu, result register
`timescale 1ns / 1ps
`default_nettype none

// Data-processing ALU with barrel shifter. A transaction is taken on every
// clock edge where start_i is high; busy_o stays low, so one operation can
// be issued every cycle. Each transaction gives exactly one result, shown on
// out_o with done_o high for a single cycle. It is held in the input register,
// then the shifter and adder path feed the result register. The receiver
// has no way to hold a result back and must capture it in the cycle where
// done_o is high. The block keeps no state between transactions.
module alu_with_barrel_shifter_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire aluws_pkg::alu_in_t in_i,
  output logic                    done_o,
  output aluws_pkg::alu_out_t     out_o
);

  logic                            valid_q;
  logic                            valid_d;
  aluws_pkg::alu_in_t              in_q;
  logic                            done_q;
  logic                            done_d;
  aluws_pkg::alu_out_t             out_q;
  aluws_pkg::alu_out_t             out_d;
  logic [aluws_pkg::WORD_W-1:0]    operand;
  logic                            shift_carry;

  // the pipeline never stalls
  assign busy_o  = 1'b0;
  assign valid_d = start_i & ~busy_o;
  assign done_d  = valid_q;

  // stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      done_q  <= done_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (valid_d) begin
      in_q <= in_i;
    end
  end

  // operand two
  aluws_shifter u_shifter (
    .rm_value_i      (in_q.rm_value),
    .operand2_code_i (in_q.operand2_code),
    .rs_amount_i     (in_q.rs_amount),
    .use_immediate_i (in_q.use_immediate),
    .carry_i         (in_q.carry_in),
    .operand_o       (operand),
    .carry_o         (shift_carry)
  );

  // operation and flags
  aluws_alu u_alu (
    .in_i          (in_q),
    .operand_i     (operand),
    .shift_carry_i (shift_carry),
    .out_o         (out_d)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (done_d) begin
      out_q <= out_d;
    end
  end

  assign done_o = done_q;
  assign out_o  = out_q;

endmodule

`default_nettype wire

>>> sv/aluws_checker.sv
// port-level checker for the alu core and its bind
`timescale 1ns / 1ps
`default_nettype none

module aluws_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start_i,
  input wire logic               busy_o,
  input wire aluws_pkg::alu_in_t in_i,
  input wire logic               done_o,
  input wire aluws_pkg::alu_out_t out_o
);

  // every accepted transaction yields a result strobe on done_o
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("accepted transaction produced no result");

  // no result without an accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result strobe without a transaction");

  // write enable follows the opcode of the matching transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_o.write_result ==
      !(($past(in_i.func, 2) == aluws_pkg::FN_TST) ||
        ($past(in_i.func, 2) == aluws_pkg::FN_TEQ) ||
        ($past(in_i.func, 2) == aluws_pkg::FN_CMP) ||
        ($past(in_i.func, 2) == aluws_pkg::FN_CMN))))
    else $error("write enable does not match opcode");

  // flags stay low when no update is requested
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !out_o.flags_valid) |->
      (!out_o.flag_neg && !out_o.flag_zero && !out_o.flag_carry && !out_o.flag_over))
    else $error("flags set without a flag update");

  // z and n agree with the result when flags are written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_o.flags_valid) |->
      ((out_o.flag_zero == (out_o.result_value == '0)) &&
       (out_o.flag_neg == out_o.result_value[aluws_pkg::WORD_W-1])))
    else $error("n or z flag disagrees with result");

endmodule

bind alu_with_barrel_shifter_core aluws_checker u_aluws_checker (.*);

`default_nettype wire
